FILE: src/mrs_pkg.sv
// Shared widths, phase codes and interface structs of the masked region
// statistics unit. No dependencies.
package mrs_pkg;

	localparam int MAX_PIXELS = 4194304;

	localparam int PX_W   = 8;
	localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W  = CNT_W + PX_W;
	localparam int SQS_W  = CNT_W + 2 * PX_W;
	localparam int ACC_W  = CNT_W + SQS_W;
	localparam int D_W    = 2 * CNT_W + 14;
	localparam int RAD_W  = D_W + 16;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int QW     = 16;
	localparam int NUM_W  = CNT_W + QW;
	localparam int PC_W   = 23;
	localparam int STD_W  = 15;
	localparam int STEP_W = 6;

	localparam logic [2:0] PH_MULP = 3'd0;
	localparam logic [2:0] PH_MULS = 3'd1;
	localparam logic [2:0] PH_SQRT = 3'd2;
	localparam logic [2:0] PH_DIVM = 3'd3;
	localparam logic [2:0] PH_DIVS = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [SUM_W-1:0] sum;
		logic [SQS_W-1:0] sumsq;
		logic [PX_W-1:0]  min;
		logic [PX_W-1:0]  max;
	} region_stats_t;

	typedef struct packed {
		logic       start;
		logic [2:0] phase;
		logic       load_out;
		logic       region;
		logic       clear;
	} ctl_cmd_t;

	typedef struct packed {
		logic done;
		logic empty;
		logic out_busy;
	} calc_stat_t;

endpackage

FILE: src/mrs_accum.sv
// Per-region accumulators (count, sum, sum of squares, min, max) and a shared overflow flag.
// Depends on mrs_pkg.
module mrs_accum (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [mrs_pkg::PX_W-1:0] pixel,
	input  logic                  in_signal,
	input  logic                  clear,
	input  logic                  sel,
	output mrs_pkg::region_stats_t stats,
	output logic                  ovf
);
	import mrs_pkg::*;

	logic [CNT_W-1:0] count_q [2];
	logic [SUM_W-1:0] sum_q   [2];
	logic [SQS_W-1:0] sq_q    [2];
	logic [PX_W-1:0]  min_q   [2];
	logic [PX_W-1:0]  max_q   [2];
	logic             ovf_q;
	logic             r;
	logic [2*PX_W-1:0] px_sq;

	assign r     = ~in_signal;
	assign px_sq = {{PX_W{1'b0}}, pixel} * {{PX_W{1'b0}}, pixel};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				count_q[i] <= '0;
				sum_q[i]   <= '0;
				sq_q[i]    <= '0;
				min_q[i]   <= '1;
				max_q[i]   <= '0;
			end
			ovf_q <= 1'b0;
		end else if (clear) begin
			for (int i = 0; i < 2; i++) begin
				count_q[i] <= '0;
				sum_q[i]   <= '0;
				sq_q[i]    <= '0;
				min_q[i]   <= '1;
				max_q[i]   <= '0;
			end
			ovf_q <= 1'b0;
		end else if (en) begin
			if (count_q[r] >= CNT_W'(MAX_PIXELS)) begin
				ovf_q <= 1'b1;
			end else begin
				count_q[r] <= count_q[r] + 1'b1;
				sum_q[r]   <= sum_q[r] + SUM_W'(pixel);
				sq_q[r]    <= sq_q[r] + SQS_W'(px_sq);
				if (pixel < min_q[r]) min_q[r] <= pixel;
				if (pixel > max_q[r]) max_q[r] <= pixel;
			end
		end
	end

	assign stats.count = count_q[sel];
	assign stats.sum   = sum_q[sel];
	assign stats.sumsq = sq_q[sel];
	assign stats.min   = min_q[sel];
	assign stats.max   = max_q[sel];
	assign ovf         = ovf_q;

endmodule

FILE: src/mrs_calc.sv
// Frame-end datapath: serial multiplier, digit-serial square root, restoring
// divider and the output word register. Depends on mrs_pkg.
module mrs_calc (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mrs_pkg::ctl_cmd_t      cmd,
	input  mrs_pkg::region_stats_t stats,
	input  logic                   ovf,
	output mrs_pkg::calc_stat_t    stat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   region,
	output logic [mrs_pkg::PC_W-1:0]  pixel_count,
	output logic [mrs_pkg::QW-1:0]    mean_q8,
	output logic [mrs_pkg::STD_W-1:0] std_q8,
	output logic [mrs_pkg::PX_W-1:0]  min_value,
	output logic [mrs_pkg::PX_W-1:0]  max_value,
	output logic                   overflow,
	output logic                   last
);
	import mrs_pkg::*;

	logic              busy_q, done_q, out_valid_q;
	logic [2:0]        phase_q;
	logic [STEP_W-1:0] cnt_q;
	logic [ACC_W-1:0]  acc_q, mcand_q, addend;
	logic [SUM_W-1:0]  mplier_q;
	logic              sub_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_sq_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W+1:0]  r2, trial, r2_diff;
	logic              sq_ge;
	logic [CNT_W-1:0]  div_rem_q;
	logic [QW-1:0]     num_lo_q, quot_q, quot_next;
	logic [CNT_W:0]    dt, dt_diff;
	logic              d_ge;
	logic              to_std_q;
	logic [QW-1:0]     mean_q;
	logic [STD_W-1:0]  std_q;
	logic [NUM_W-1:0]  num_mean, num_std;
	logic              empty, last_step;

	assign empty     = (stats.count == '0);
	assign last_step = busy_q && (cnt_q == '0);

	assign addend  = mplier_q[0] ? mcand_q : '0;

	assign r2      = {rem_sq_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = (REM_W+2)'({root_q, 2'b01});
	assign sq_ge   = (r2 >= trial);
	assign r2_diff = r2 - trial;

	assign dt        = {div_rem_q, num_lo_q[QW-1]};
	assign d_ge      = (dt >= {1'b0, stats.count});
	assign dt_diff   = dt - {1'b0, stats.count};
	assign quot_next = {quot_q[QW-2:0], d_ge};

	assign num_mean = {stats.sum, {PX_W{1'b0}}};
	assign num_std  = NUM_W'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			done_q <= last_step;
			if (cmd.start) busy_q <= 1'b1;
			else if (last_step) busy_q <= 1'b0;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			phase_q <= cmd.phase;
			unique case (cmd.phase)
				PH_MULP: begin
					acc_q    <= '0;
					mcand_q  <= ACC_W'(stats.sumsq);
					mplier_q <= SUM_W'(stats.count);
					sub_q    <= 1'b0;
					cnt_q    <= STEP_W'(CNT_W - 1);
				end
				PH_MULS: begin
					mcand_q  <= ACC_W'(stats.sum);
					mplier_q <= stats.sum;
					sub_q    <= 1'b1;
					cnt_q    <= STEP_W'(SUM_W - 1);
				end
				PH_SQRT: begin
					rad_q    <= {acc_q[D_W-1:0], 16'b0};
					rem_sq_q <= '0;
					root_q   <= '0;
					cnt_q    <= STEP_W'(ROOT_W - 1);
				end
				PH_DIVM: begin
					div_rem_q <= num_mean[NUM_W-1:QW];
					num_lo_q  <= num_mean[QW-1:0];
					to_std_q  <= 1'b0;
					cnt_q     <= STEP_W'(QW - 1);
				end
				PH_DIVS: begin
					div_rem_q <= num_std[NUM_W-1:QW];
					num_lo_q  <= num_std[QW-1:0];
					to_std_q  <= 1'b1;
					cnt_q     <= STEP_W'(QW - 1);
				end
				default: begin
				end
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			unique case (phase_q)
				PH_MULP, PH_MULS: begin
					acc_q    <= sub_q ? acc_q - addend : acc_q + addend;
					mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[SUM_W-1:1]};
				end
				PH_SQRT: begin
					rem_sq_q <= sq_ge ? r2_diff[REM_W-1:0] : r2[REM_W-1:0];
					root_q   <= {root_q[ROOT_W-2:0], sq_ge};
					rad_q    <= {rad_q[RAD_W-3:0], 2'b00};
				end
				PH_DIVM, PH_DIVS: begin
					div_rem_q <= d_ge ? dt_diff[CNT_W-1:0] : dt[CNT_W-1:0];
					num_lo_q  <= {num_lo_q[QW-2:0], 1'b0};
					quot_q    <= quot_next;
					if (cnt_q == '0) begin
						if (to_std_q) std_q <= quot_next[STD_W-1:0];
						else mean_q <= quot_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			region      <= cmd.region;
			pixel_count <= PC_W'(stats.count);
			mean_q8     <= empty ? '0 : mean_q;
			std_q8      <= empty ? '0 : std_q;
			min_value   <= empty ? '0 : stats.min;
			max_value   <= empty ? '0 : stats.max;
			overflow    <= ovf;
			last        <= cmd.region;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.done     = done_q;
	assign stat.empty    = empty;
	assign stat.out_busy = out_valid_q & ~out_ready;

endmodule

FILE: src/mrs_ctrl.sv
// Frame-end sequencer: walks each non-empty region through the datapath
// phases and hands each result to the output register. Depends on mrs_pkg.
module mrs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                last_pixel,
	input  mrs_pkg::calc_stat_t stat,
	output mrs_pkg::ctl_cmd_t   cmd,
	output logic                in_ready
);
	import mrs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_MULP  = 3'd2;
	localparam logic [2:0] S_MULS  = 3'd3;
	localparam logic [2:0] S_SQRT  = 3'd4;
	localparam logic [2:0] S_DIVM  = 3'd5;
	localparam logic [2:0] S_DIVS  = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q;
	logic       go_q, region_q, load;
	logic [2:0] phase;

	assign load     = (state_q == S_OUT) && !stat.out_busy;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		unique case (state_q)
			S_MULS:  phase = PH_MULS;
			S_SQRT:  phase = PH_SQRT;
			S_DIVM:  phase = PH_DIVM;
			S_DIVS:  phase = PH_DIVS;
			default: phase = PH_MULP;
		endcase
	end

	assign cmd.start    = go_q;
	assign cmd.phase    = phase;
	assign cmd.load_out = load;
	assign cmd.region   = region_q;
	assign cmd.clear    = load & region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			go_q     <= 1'b0;
			region_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && last_pixel) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (stat.empty) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MULP;
						go_q    <= 1'b1;
					end
				end
				S_MULP: begin
					if (stat.done) begin
						state_q <= S_MULS;
						go_q    <= 1'b1;
					end
				end
				S_MULS: begin
					if (stat.done) begin
						state_q <= S_SQRT;
						go_q    <= 1'b1;
					end
				end
				S_SQRT: begin
					if (stat.done) begin
						state_q <= S_DIVM;
						go_q    <= 1'b1;
					end
				end
				S_DIVM: begin
					if (stat.done) begin
						state_q <= S_DIVS;
						go_q    <= 1'b1;
					end
				end
				S_DIVS: begin
					if (stat.done) state_q <= S_OUT;
				end
				S_OUT: begin
					if (load) begin
						if (region_q) begin
							region_q <= 1'b0;
							state_q  <= S_IDLE;
						end else begin
							region_q <= 1'b1;
							state_q  <= S_CHECK;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: src/masked_region_statistics_unit.sv
// Masked region statistics unit, top level.
// Instantiates mrs_accum, mrs_ctrl and mrs_calc; depends on mrs_pkg.
//
// Input channel (in_valid/in_ready): one word per pixel with its value, its
// mask tag (in_signal) and last_pixel on the frame's final pixel. Pixels are
// taken one per cycle while the unit is idle.
// Output channel (out_valid/out_ready): two words per frame, signal region
// first, then noise region with last set.
// Each non-empty region is worked out after the last pixel by a serial
// multiply of CNT_W + SUM_W steps, 38 root digits and two 16-bit divides,
// one bit per cycle each; an empty region skips these phases. in_ready
// stays low from the last pixel until the noise word is in the output
// register.
// A stalled receiver holds the output word; the noise computation runs while
// the signal word waits, and pixels of the next frame are taken while the
// noise word waits.
// Reset clears all region statistics and the overflow flag; the same clear
// happens when the noise word is loaded.
module masked_region_statistics_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [mrs_pkg::PX_W-1:0]  pixel,
	input  logic                      in_signal,
	input  logic                      last_pixel,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      region,
	output logic [mrs_pkg::PC_W-1:0]  pixel_count,
	output logic [mrs_pkg::QW-1:0]    mean_q8,
	output logic [mrs_pkg::STD_W-1:0] std_q8,
	output logic [mrs_pkg::PX_W-1:0]  min_value,
	output logic [mrs_pkg::PX_W-1:0]  max_value,
	output logic                      overflow,
	output logic                      last
);
	import mrs_pkg::*;

	region_stats_t stats;
	ctl_cmd_t      cmd;
	calc_stat_t    stat;
	logic          ovf, in_fire;

	assign in_fire = in_valid & in_ready;

	mrs_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (in_fire),
		.pixel     (pixel),
		.in_signal (in_signal),
		.clear     (cmd.clear),
		.sel       (cmd.region),
		.stats     (stats),
		.ovf       (ovf)
	);

	mrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.last_pixel (last_pixel),
		.stat       (stat),
		.cmd        (cmd),
		.in_ready   (in_ready)
	);

	mrs_calc u_calc (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stats       (stats),
		.ovf         (ovf),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.region      (region),
		.pixel_count (pixel_count),
		.mean_q8     (mean_q8),
		.std_q8      (std_q8),
		.min_value   (min_value),
		.max_value   (max_value),
		.overflow    (overflow),
		.last        (last)
	);

endmodule

FILE: src/mrs_checker.sv
// Port-level checks for the masked region statistics unit, bound to the top.
// Depends on mrs_pkg.
module mrs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      region,
	input logic [mrs_pkg::PC_W-1:0]  pixel_count,
	input logic [mrs_pkg::QW-1:0]    mean_q8,
	input logic [mrs_pkg::STD_W-1:0] std_q8,
	input logic [mrs_pkg::PX_W-1:0]  min_value,
	input logic [mrs_pkg::PX_W-1:0]  max_value,
	input logic                      last
);
	import mrs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(region) &&
			$stable(pixel_count) && $stable(mean_q8) && $stable(std_q8))
		else $error("output word changed while stalled");

	a_last_is_noise: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == region))
		else $error("last does not mark the noise word");

	a_busy_on_signal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !region |-> !in_ready)
		else $error("pixels taken before the noise word is ready");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_count == '0 |-> mean_q8 == '0 && std_q8 == '0 &&
			min_value == '0 && max_value == '0)
		else $error("empty region word not all zero");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_count != '0 |-> min_value <= max_value &&
			mean_q8[QW-1:8] >= min_value && mean_q8[QW-1:8] <= max_value)
		else $error("min, mean and max out of order");

endmodule

bind masked_region_statistics_unit mrs_checker u_mrs_checker (.*);

FILE: verif/region_stats_checker.sv
`timescale 1ns / 1ps
// Checker for masked_region_statistics_unit: it watches both channels and keeps its own per-region
// statistics of every accepted pixel word, then checks each result word against them.
// Depends on mrs_pkg for field widths and MAX_PIXELS.
module region_stats_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [mrs_pkg::PX_W-1:0]  pixel,
	input  logic                      in_signal,
	input  logic                      last_pixel,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic                      region,
	input  logic [mrs_pkg::PC_W-1:0]  pixel_count,
	input  logic [mrs_pkg::QW-1:0]    mean_q8,
	input  logic [mrs_pkg::STD_W-1:0] std_q8,
	input  logic [mrs_pkg::PX_W-1:0]  min_value,
	input  logic [mrs_pkg::PX_W-1:0]  max_value,
	input  logic                      overflow,
	input  logic                      last,
	output int                        errors,
	output int                        pending
);
	import mrs_pkg::*;

	typedef struct packed {
		logic             region;
		logic [PC_W-1:0]  count;
		logic [QW-1:0]    mean;
		logic [STD_W-1:0] std;
		logic [PX_W-1:0]  lo_value;
		logic [PX_W-1:0]  hi_value;
		logic             ovf;
		logic             lst;
	} region_result_t;

	region_result_t frame_results_q[$];
	region_result_t word_expected;

	// index 0 is the signal region, 1 the noise region
	logic [63:0]     acc_count[2];
	logic [63:0]     acc_sum[2];
	logic [63:0]     acc_sumsq[2];
	logic [PX_W-1:0] acc_lo[2];
	logic [PX_W-1:0] acc_hi[2];
	logic            ovf_seen;

	initial errors = 0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// largest q below 2^STD_W with (q*n)^2 <= 65536*d
	function automatic logic [STD_W-1:0] deviation_q8(input logic [127:0] d,
			input logic [127:0] n);
		logic [127:0] rad;
		logic [127:0] q;
		logic [127:0] t;
		logic [127:0] prod;
		int b;
		rad = d << 16;
		q = '0;
		for (b = STD_W - 1; b >= 0; b--) begin
			t = q | (128'd1 << b);
			prod = t * n;
			if (prod * prod <= rad)
				q = t;
		end
		return q[STD_W-1:0];
	endfunction

	function automatic region_result_t summarize(input int r);
		region_result_t res;
		logic [127:0] n;
		logic [127:0] s;
		logic [127:0] sq;
		logic [127:0] d;
		logic [127:0] m;
		n = 128'(acc_count[r]);
		s = 128'(acc_sum[r]);
		sq = 128'(acc_sumsq[r]);
		res.region = (r == 1);
		res.count = n[PC_W-1:0];
		res.ovf = ovf_seen;
		res.lst = (r == 1);
		if (n == 0) begin
			res.mean = '0;
			res.std = '0;
			res.lo_value = '0;
			res.hi_value = '0;
		end else begin
			d = n * sq - s * s;
			m = (s << 8) / n;
			res.mean = m[QW-1:0];
			res.std = deviation_q8(d, n);
			res.lo_value = acc_lo[r];
			res.hi_value = acc_hi[r];
		end
		return res;
	endfunction

	task automatic clear_stats();
		int r;
		for (r = 0; r < 2; r++) begin
			acc_count[r] = '0;
			acc_sum[r] = '0;
			acc_sumsq[r] = '0;
			acc_lo[r] = 8'd255;
			acc_hi[r] = 8'd0;
		end
		ovf_seen = 1'b0;
	endtask

	task automatic fold_pixel(input logic [PX_W-1:0] px, input logic sig, input logic lst);
		int r;
		r = sig ? 0 : 1;
		if (acc_count[r] >= 64'(MAX_PIXELS)) begin
			ovf_seen = 1'b1;
		end else begin
			acc_count[r] += 64'd1;
			acc_sum[r] += 64'(px);
			acc_sumsq[r] += 64'(px) * 64'(px);
			if (px < acc_lo[r])
				acc_lo[r] = px;
			if (px > acc_hi[r])
				acc_hi[r] = px;
		end
		if (lst) begin
			frame_results_q.insert(frame_results_q.size(), summarize(0));
			frame_results_q.insert(frame_results_q.size(), summarize(1));
			clear_stats();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stats();
			frame_results_q.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (frame_results_q.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					word_expected = frame_results_q.pop_front();
					check_field("region", 64'(region), 64'(word_expected.region));
					check_field("pixel_count", 64'(pixel_count), 64'(word_expected.count));
					check_field("mean_q8", 64'(mean_q8), 64'(word_expected.mean));
					check_field("std_q8", 64'(std_q8), 64'(word_expected.std));
					check_field("min_value", 64'(min_value), 64'(word_expected.lo_value));
					check_field("max_value", 64'(max_value), 64'(word_expected.hi_value));
					check_field("overflow", 64'(overflow), 64'(word_expected.ovf));
					check_field("last", 64'(last), 64'(word_expected.lst));
				end
			end
			if (in_valid && in_ready)
				fold_pixel(pixel, in_signal, last_pixel);
			pending = frame_results_q.size();
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Top of the masked_region_statistics_unit testbench: clock, reset, pixel stimulus and receiver
// stalls. Instantiates the unit and region_stats_checker, and gives the verdict. Depends on mrs_pkg.
module tb;
	import mrs_pkg::*;

	localparam int IDLE_LIMIT  = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int ITEM_TARGET = 800;
	localparam int TAIL_CYCLES = 400;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic [PX_W-1:0] pixel = '0;
	logic            in_signal = 1'b0;
	logic            last_pixel = 1'b0;
	logic            out_ready = 1'b0;

	logic             in_ready;
	logic             out_valid;
	logic             region;
	logic [PC_W-1:0]  pixel_count;
	logic [QW-1:0]    mean_q8;
	logic [STD_W-1:0] std_q8;
	logic [PX_W-1:0]  min_value;
	logic [PX_W-1:0]  max_value;
	logic             overflow;
	logic             last;

	int errors;
	int pending;
	int idle_cycles = 0;
	int words_sent = 0;
	bit no_idle = 1'b0;
	bit hold_off_req = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	masked_region_statistics_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel(pixel), .in_signal(in_signal), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.region(region), .pixel_count(pixel_count), .mean_q8(mean_q8), .std_q8(std_q8),
		.min_value(min_value), .max_value(max_value), .overflow(overflow), .last(last)
	);

	region_stats_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel(pixel), .in_signal(in_signal), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_ready(out_ready),
		.region(region), .pixel_count(pixel_count), .mean_q8(mean_q8), .std_q8(std_q8),
		.min_value(min_value), .max_value(max_value), .overflow(overflow), .last(last),
		.errors(errors), .pending(pending)
	);

	task automatic send_word(input logic [PX_W-1:0] px, input logic sig, input logic lst);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= px;
		in_signal <= sig;
		last_pixel <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
	endtask

	function automatic logic [PX_W-1:0] draw_pixel(input int style, input logic [PX_W-1:0] base);
		logic [PX_W-1:0] px;
		case (style)
			0: px = PX_W'($urandom);
			1: px = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
			2: px = base + PX_W'($urandom_range(0, 3));
			default: px = base;
		endcase
		return px;
	endfunction

	// mask_mode: 0 random tags, 1 all signal, 2 all noise, 3 mostly signal
	task automatic send_frame(input int len, input int mask_mode);
		int i;
		int style;
		logic [PX_W-1:0] base;
		logic sig;
		style = $urandom_range(0, 3);
		base = PX_W'($urandom);
		for (i = 0; i < len; i++) begin
			case (mask_mode)
				0: sig = 1'($urandom_range(0, 1));
				1: sig = 1'b1;
				2: sig = 1'b0;
				default: sig = ($urandom_range(0, 7) != 0);
			endcase
			send_word(draw_pixel(style, base), sig, i == len - 1);
		end
	endtask

	initial begin
		int frame_no;
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// single pixel frames: one region empty each time
		send_word(8'd0, 1'b1, 1'b1);
		send_word(8'd255, 1'b0, 1'b1);
		// widest spread in both regions
		send_word(8'd0, 1'b1, 1'b0);
		send_word(8'd255, 1'b1, 1'b0);
		send_word(8'd255, 1'b0, 1'b0);
		send_word(8'd0, 1'b0, 1'b1);
		// top mean, zero deviation in the signal region
		send_word(8'd255, 1'b1, 1'b0);
		send_word(8'd255, 1'b1, 1'b0);
		send_word(8'd255, 1'b1, 1'b0);
		send_word(8'd255, 1'b1, 1'b0);
		send_word(8'd128, 1'b0, 1'b0);
		send_word(8'd127, 1'b0, 1'b1);
		// alternating bit patterns
		send_word(8'hAA, 1'b1, 1'b0);
		send_word(8'h55, 1'b0, 1'b0);
		send_word(8'h0F, 1'b1, 1'b0);
		send_word(8'hF0, 1'b0, 1'b1);

		frame_no = 0;
		while (words_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 4) == 0);
			if (frame_no == 3) begin
				// short frame under a long receiver hold-off: the next frame backs up
				hold_off_req = 1'b1;
				len = 5;
			end else if ($urandom_range(0, 7) == 0) begin
				len = $urandom_range(100, 200);
			end else begin
				len = $urandom_range(1, 30);
			end
			if (len > ITEM_TARGET - words_sent)
				len = ITEM_TARGET - words_sent;
			send_frame(len, $urandom_range(0, 3));
			frame_no++;
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("masked_region_statistics_unit regression: pass");
		else
			$display("masked_region_statistics_unit regression: fail");
		$finish;
	end

	initial begin
		int stall;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = no_idle ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid && !hold_off_req) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("masked_region_statistics_unit regression: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
